[rtl/geoh_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// geoh_pkg
// Shared widths, defaults and the base32 character table of the geohash
// encoder.
// ============================================================================
package geoh_pkg;

    localparam int IN_W           = 40;   // fixed-point degree inputs
    localparam int CHAR_W         = 7;    // ASCII character
    localparam int POS_W          = 4;    // character index
    localparam int CNT_W          = 4;    // char_count register
    localparam int MAX_CHARS      = 12;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int CODE_W         = 5;    // bits per character

    localparam logic [CNT_W-1:0] CHAR_COUNT_RESET = 4'd12;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CODE_W-1:0] code_t;

    localparam char_t ALPHABET [0:31] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
    };

    function automatic char_t geoh_char(input code_t code);
        return ALPHABET[code];
    endfunction

    // Full latitude span (180 degrees) in fixed point.
    function automatic longint geoh_lat_span(input int fb);
        return 64'sd180 << fb;
    endfunction

    // Full longitude span (360 degrees) in fixed point.
    function automatic longint geoh_lon_span(input int fb);
        return 64'sd360 << fb;
    endfunction

endpackage

[rtl/geohash_encoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// geohash_encoder
// Fixed-point latitude/longitude to base32 geohash, one character per
// output transaction.
// ============================================================================
// A point enters a three-stage normalizing pipeline (clamp, wrap, offset) and
// then a character generator that emits one geohash character per cycle
// while the result channel is ready. A point occupies the generator for
// char_count characters (12 after reset), and the generator takes the next
// point only as it emits the last character of the current one; the
// pipeline takes a new point every cycle while the generator is busy until
// its stages fill. char_count of 0 acts as 1 and values above 12 act as 12.
// cfg_ready is always high; write char_count only while the block is idle.
module geohash_encoder #(
    parameter int FRAC_BITS = geoh_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [geoh_pkg::IN_W-1:0]   s_lat_fixed,
    input  logic signed [geoh_pkg::IN_W-1:0]   s_lon_fixed,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [geoh_pkg::CHAR_W-1:0] m_hash_char,
    output logic        [geoh_pkg::POS_W-1:0]  m_char_position,
    output logic                               m_last_char,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [geoh_pkg::CNT_W-1:0]  cfg_char_count
);
    import geoh_pkg::*;

    logic [CNT_W-1:0]       char_count_reg;
    logic [CNT_W-1:0]       count_eff;

    logic                   n_valid;
    logic                   n_ready;
    logic [FRAC_BITS+7:0]   n_lat_rem;
    logic [FRAC_BITS+8:0]   n_lon_rem;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg <= CHAR_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            char_count_reg <= cfg_char_count;
        end
    end

    always_comb begin
        priority if (char_count_reg == '0) begin
            count_eff = CNT_W'(1);
        end else if (char_count_reg > CNT_W'(MAX_CHARS)) begin
            count_eff = CNT_W'(MAX_CHARS);
        end else begin
            count_eff = char_count_reg;
        end
    end

    geoh_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_lat      (s_lat_fixed),
        .in_lon      (s_lon_fixed),
        .out_valid   (n_valid),
        .out_ready   (n_ready),
        .out_lat_rem (n_lat_rem),
        .out_lon_rem (n_lon_rem)
    );

    geoh_chargen #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chargen (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (n_valid),
        .in_ready        (n_ready),
        .in_lat_rem      (n_lat_rem),
        .in_lon_rem      (n_lon_rem),
        .count           (count_eff),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hash_char     (m_hash_char),
        .m_char_position (m_char_position),
        .m_last_char     (m_last_char)
    );

endmodule

[rtl/geoh_norm.sv]
`timescale 1ns / 1ps
// ============================================================================
// geoh_norm
// Three-stage pipeline: latitude clamp, longitude wrap by 360 degrees, and
// offset of both axes to unsigned bisection remainders.
// ============================================================================
module geoh_norm #(
    parameter int FRAC_BITS = geoh_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [geoh_pkg::IN_W-1:0]   in_lat,
    input  logic signed [geoh_pkg::IN_W-1:0]   in_lon,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [FRAC_BITS+7:0]        out_lat_rem,
    output logic        [FRAC_BITS+8:0]        out_lon_rem
);
    import geoh_pkg::*;

    localparam int LAT_W = FRAC_BITS + 8;
    localparam int LON_W = FRAC_BITS + 9;
    // two guard bits: longitude plus half a turn can pass 2^40 at 32 fraction bits
    localparam int T_W   = IN_W + 2;
    // 360 degrees = 45 * 2^(FRAC_BITS+3): low bits pass, high part mod 45
    localparam int LOW_W = FRAC_BITS + 3;
    localparam int HI_W  = T_W - LOW_W;
    localparam int UW    = HI_W + 1;
    localparam int MSH   = UW + 6;
    localparam int MW    = UW + 1;
    localparam int QW    = UW - 5;
    localparam int HR_W  = 6;

    localparam longint OFS   = 45 * (((64'sd1 << (HI_W - 1)) + 44) / 45);
    localparam longint RECIP = ((64'sd1 << MSH) + 44) / 45;

    localparam logic [LAT_W-1:0] LAT_SPAN = LAT_W'(geoh_lat_span(FRAC_BITS));
    localparam logic [LON_W-1:0] LON_SPAN = LON_W'(geoh_lon_span(FRAC_BITS));
    localparam logic signed [IN_W-1:0] LAT_HALF =
        IN_W'(geoh_lat_span(FRAC_BITS) >> 1);
    localparam logic signed [IN_W-1:0] LAT_LOW  = -LAT_HALF;
    localparam logic signed [T_W-1:0]  LON_HALF =
        T_W'(geoh_lon_span(FRAC_BITS) >> 1);

    // stage 1: input register
    logic                   s1_valid_reg;
    logic signed [IN_W-1:0] s1_lat_reg, s1_lon_reg;
    // stage 2: after reciprocal multiply
    logic                   s2_valid_reg;
    logic [LAT_W-1:0]       s2_lat_rem_reg;
    logic [LOW_W-1:0]       s2_low_reg;
    logic [UW-1:0]          s2_u_reg;
    logic [QW-1:0]          s2_q_reg;
    logic                   s2_tpos_reg;
    // stage 3: normalized remainders
    logic                   s3_valid_reg;
    logic [LAT_W-1:0]       s3_lat_rem_reg;
    logic [LON_W-1:0]       s3_lon_rem_reg;

    logic s1_en, s2_en, s3_en;

    logic signed [IN_W-1:0] lat_cl;
    logic        [IN_W-1:0] lat_sum;
    logic signed [T_W-1:0]  t_s1;
    logic        [HI_W-1:0] hi_s1;
    logic        [UW-1:0]   u_s1;
    logic [UW+MW-1:0]       prod_s1;
    logic                   tpos_s1;

    logic [UW-1:0]          qx45;
    logic [UW-1:0]          hr_full;
    logic [LON_W-1:0]       r_s2;
    logic [LON_W-1:0]       lon_rem_s2;

    assign s3_en    = !s3_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    // ---- stage 1 logic
    always_comb begin
        if (s1_lat_reg < LAT_LOW) begin
            lat_cl = LAT_LOW;
        end else if (s1_lat_reg > LAT_HALF) begin
            lat_cl = LAT_HALF;
        end else begin
            lat_cl = s1_lat_reg;
        end
    end

    assign lat_sum = lat_cl + LAT_HALF;
    assign t_s1    = $signed({{2{s1_lon_reg[IN_W-1]}}, s1_lon_reg}) + LON_HALF;
    assign hi_s1   = t_s1[T_W-1:LOW_W];
    // bias the signed high part by a multiple of 45 so the mod is unsigned
    assign u_s1    = {hi_s1[HI_W-1], hi_s1} + UW'(OFS);
    assign prod_s1 = (UW+MW)'(u_s1) * (UW+MW)'(RECIP);
    assign tpos_s1 = !t_s1[T_W-1] && (t_s1 != '0);

    // ---- stage 2 logic
    assign qx45       = UW'(s2_q_reg) * UW'(45);
    assign hr_full    = s2_u_reg - qx45;
    assign r_s2       = {hr_full[HR_W-1:0], s2_low_reg};
    // exact positive multiple of a turn lands on the top edge, not zero
    assign lon_rem_s2 = ((r_s2 == '0) && s2_tpos_reg) ? LON_SPAN : r_s2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en && in_valid) begin
            s1_lat_reg <= in_lat;
            s1_lon_reg <= in_lon;
        end
        if (s2_en && s1_valid_reg) begin
            s2_lat_rem_reg <= lat_sum[LAT_W-1:0];
            s2_low_reg     <= t_s1[LOW_W-1:0];
            s2_u_reg       <= u_s1;
            s2_q_reg       <= prod_s1[MSH +: QW];
            s2_tpos_reg    <= tpos_s1;
        end
        if (s3_en && s2_valid_reg) begin
            s3_lat_rem_reg <= s2_lat_rem_reg;
            s3_lon_rem_reg <= lon_rem_s2;
        end
    end

    assign out_valid   = s3_valid_reg;
    assign out_lat_rem = s3_lat_rem_reg;
    assign out_lon_rem = s3_lon_rem_reg;

`ifndef SYNTHESIS
    a_lon_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_lon_rem_reg <= LON_SPAN))
        else $error("longitude remainder above span");

    a_lat_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_lat_rem_reg <= LAT_SPAN))
        else $error("latitude remainder above span");
`endif

endmodule

[rtl/geoh_chargen.sv]
`timescale 1ns / 1ps
// ============================================================================
// geoh_chargen
// Character generator: per unstalled cycle, five interleaved bisection steps
// (three on one axis, two on the other) give one registered base32 character.
// ============================================================================
module geoh_chargen #(
    parameter int FRAC_BITS = geoh_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [FRAC_BITS+7:0]          in_lat_rem,
    input  logic [FRAC_BITS+8:0]          in_lon_rem,
    input  logic [geoh_pkg::CNT_W-1:0]    count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [geoh_pkg::CHAR_W-1:0]   m_hash_char,
    output logic [geoh_pkg::POS_W-1:0]    m_char_position,
    output logic                          m_last_char
);
    import geoh_pkg::*;

    localparam int LAT_W = FRAC_BITS + 8;
    localparam int LON_W = FRAC_BITS + 9;
    localparam int STEPS = 3;

    localparam logic [LAT_W-1:0] LAT_SPAN = LAT_W'(geoh_lat_span(FRAC_BITS));
    localparam logic [LON_W-1:0] LON_SPAN = LON_W'(geoh_lon_span(FRAC_BITS));

    logic             busy_reg;
    logic [LAT_W-1:0] lat_w_reg;
    logic [LON_W-1:0] lon_w_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] last_pos_reg;

    logic             m_valid_reg;
    char_t            m_char_reg;
    logic [POS_W-1:0] m_pos_reg;
    logic             m_last_reg;

    logic [LAT_W-1:0] lat_r [0:STEPS];
    logic [LON_W-1:0] lon_r [0:STEPS];
    logic [STEPS-1:0] lat_b, lon_b;
    logic [LAT_W:0]   lat_sh [0:STEPS-1];
    logic [LON_W:0]   lon_sh [0:STEPS-1];

    code_t            code;
    logic [LAT_W-1:0] lat_next;
    logic [LON_W-1:0] lon_next;

    logic out_free, fire, at_last, done, load;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = busy_reg && out_free;
    assign at_last  = (pos_reg == last_pos_reg);
    assign done     = fire && at_last;
    assign in_ready = !busy_reg || done;
    assign load     = in_valid && in_ready;

    // restoring division steps, independent per axis
    always_comb begin
        lat_r[0] = lat_w_reg;
        lon_r[0] = lon_w_reg;
        for (int j = 0; j < STEPS; j++) begin
            lat_sh[j] = {lat_r[j], 1'b0};
            lat_b[j]  = (lat_sh[j] >= {1'b0, LAT_SPAN});
            lat_r[j+1] = lat_b[j] ? LAT_W'(lat_sh[j] - {1'b0, LAT_SPAN})
                                  : lat_sh[j][LAT_W-1:0];
            lon_sh[j] = {lon_r[j], 1'b0};
            lon_b[j]  = (lon_sh[j] >= {1'b0, LON_SPAN});
            lon_r[j+1] = lon_b[j] ? LON_W'(lon_sh[j] - {1'b0, LON_SPAN})
                                  : lon_sh[j][LON_W-1:0];
        end
    end

    // even characters start on a longitude bit, odd ones on a latitude bit
    always_comb begin
        if (!pos_reg[0]) begin
            code     = {lon_b[0], lat_b[0], lon_b[1], lat_b[1], lon_b[2]};
            lon_next = lon_r[3];
            lat_next = lat_r[2];
        end else begin
            code     = {lat_b[0], lon_b[0], lat_b[1], lon_b[1], lat_b[2]};
            lon_next = lon_r[2];
            lat_next = lat_r[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lat_w_reg    <= in_lat_rem;
            lon_w_reg    <= in_lon_rem;
            pos_reg      <= '0;
            last_pos_reg <= POS_W'(count - 1'b1);
        end else if (fire) begin
            lat_w_reg <= lat_next;
            lon_w_reg <= lon_next;
            pos_reg   <= POS_W'(pos_reg + 1'b1);
        end
        if (fire) begin
            m_char_reg <= geoh_char(code);
            m_pos_reg  <= pos_reg;
            m_last_reg <= at_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hash_char     = m_char_reg;
    assign m_char_position = m_pos_reg;
    assign m_last_char     = m_last_reg;

`ifndef SYNTHESIS
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !m_last_reg) |=>
            (m_valid_reg && (m_pos_reg == POS_W'($past(m_pos_reg) + 1'b1))))
        else $error("character stream broken inside a geohash");

    a_pos_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_pos_reg <= POS_W'(MAX_CHARS - 1)))
        else $error("character position beyond maximum");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg <= last_pos_reg))
        else $error("working position past last character");
`endif

endmodule
